// File: rtl/vae_pkg.sv
// types and constants shared by the velocity and acceleration estimator
package vae_pkg;

  localparam int DATA_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = 33;
  localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W     = 56;
  localparam int DIVD_HI_W = 22;
  localparam int CNT_W     = 5;
  localparam int BLEND_W   = ACC_W - 15;

  // 1e6 = 15 * 2^16 + 16960
  localparam logic [GAIN_W-1:0] US_HI = 16'd15;
  localparam logic [GAIN_W-1:0] US_LO = 16'd16960;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_ZERO = 16'd0;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic [ACC_W-1:0] ROUND_HALF = 56'd16384;
  localparam logic [CNT_W-1:0] LAST_BIT = 5'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEL_GAIN_NEW = 2'd0,
    REG_VEL_GAIN_OLD = 2'd1,
    REG_ACC_GAIN_NEW = 2'd2,
    REG_ACC_GAIN_OLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_HI,
    S_MUL_LO,
    S_DIV_PREP,
    S_DIV_LOAD,
    S_DIV_ITER,
    S_DIV_DONE,
    S_BLEND_NEW,
    S_BLEND_OLD,
    S_BLEND_DONE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_ROUND
  } acc_base_t;

  typedef struct packed {
    logic [STAMP_W-1:0]       stamp_us;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } meas_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] acc_x;
    logic signed [DATA_W-1:0] acc_y;
    logic signed [DATA_W-1:0] acc_z;
    logic                     updated;
  } est_t;

endpackage

// File: rtl/velocity_acceleration_estimator.sv
// velocity and acceleration estimator: finite difference, rate divide and first-order filter
// Each request carries a microsecond stamp and a Q15.16 position per axis; one estimate
// comes back per request. A first sample or one with a zero interval does not advance
// the filters. One shared 16x33 multiplier and one shared one-bit-per-cycle divider
// under a sequencer do the work: per axis, velocity and acceleration each need two
// multiplies for the 1e6 scale, a 32-step division by the interval and two multiplies
// for the filter. No new request is taken while a sample is being worked on; a finished
// estimate sits in an output register, so the next request is taken while it waits
// to be read.
module velocity_acceleration_estimator
  import vae_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 meas_valid,
  output logic                 meas_stall,
  input  meas_t                meas,
  output logic                 est_valid,
  input  logic                 est_stall,
  output est_t                 est
);

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  state_t state, state_next;

  logic [GAIN_W-1:0] vel_gain_new, vel_gain_old, acc_gain_new, acc_gain_old;

  logic [STAMP_W-1:0]       prev_stamp;
  logic                     have_prev;
  logic signed [DATA_W-1:0] prev_pos [AXES];
  logic signed [DATA_W-1:0] vel      [AXES];
  logic signed [DATA_W-1:0] accel    [AXES];

  meas_t                    cur;
  logic [STAMP_W-1:0]       den;
  logic                     advance;
  logic [AXW-1:0]           axis;
  logic                     phase;
  logic signed [DIFF_W-1:0] num;
  logic signed [ACC_W-1:0]  acc;
  logic                     neg;
  logic                     sat;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        quo;
  logic [CNT_W-1:0]         bit_cnt;
  logic signed [DATA_W-1:0] raw;
  logic signed [DATA_W-1:0] vold;

  // combinational signals
  logic [STAMP_W-1:0]       interval;
  logic                     adv_now;
  logic signed [DATA_W-1:0] cur_pos [3];
  logic                     last_axis;
  logic                     est_free;

  logic [GAIN_W-1:0]        mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic                     mul_shift;
  acc_base_t                acc_base;
  logic                     acc_load;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  base_val;
  logic signed [ACC_W-1:0]  acc_sum;

  logic [DATA_W-1:0]        half_den;
  logic [ACC_W-1:0]         dividend;
  logic [DIVD_HI_W-1:0]     div_hi;
  logic [DATA_W:0]          r2;
  logic [DATA_W:0]          r2_sub;
  logic                     ge;
  logic signed [DATA_W-1:0] div_res;

  logic signed [BLEND_W-1:0] blend_sh;
  logic signed [DATA_W-1:0]  blend_res;

  logic signed [DATA_W-1:0] vel_out [3];
  logic signed [DATA_W-1:0] acc_out [3];
  est_t                     est_next;

  assign interval  = meas.stamp_us - prev_stamp;
  assign adv_now   = have_prev && (interval != '0);
  assign last_axis = (axis == AXW'(AXES - 1));
  assign est_free  = !est_valid || !est_stall;

  assign cur_pos[0] = cur.pos_x;
  assign cur_pos[1] = cur.pos_y;
  assign cur_pos[2] = cur.pos_z;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (meas_valid) begin
          state_next = adv_now ? S_DIFF : S_FINISH;
        end
      end
      S_DIFF:      state_next = S_MUL_HI;
      S_MUL_HI:    state_next = S_MUL_LO;
      S_MUL_LO:    state_next = S_DIV_PREP;
      S_DIV_PREP:  state_next = S_DIV_LOAD;
      S_DIV_LOAD:  state_next = S_DIV_ITER;
      S_DIV_ITER: begin
        if (bit_cnt == LAST_BIT) begin
          state_next = S_DIV_DONE;
        end
      end
      S_DIV_DONE:  state_next = S_BLEND_NEW;
      S_BLEND_NEW: state_next = S_BLEND_OLD;
      S_BLEND_OLD: state_next = S_BLEND_DONE;
      S_BLEND_DONE: begin
        if (phase && last_axis) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_FINISH: begin
        if (est_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs: shared multiplier operands and accumulator mode
  always_comb begin
    mul_a      = US_HI;
    mul_b      = num;
    mul_shift  = 1'b0;
    acc_base   = BASE_ZERO;
    acc_load   = 1'b0;
    meas_stall = (state != S_IDLE);
    case (state)
      S_MUL_HI: begin
        mul_a     = US_HI;
        mul_b     = num;
        mul_shift = 1'b1;
        acc_base  = BASE_ZERO;
        acc_load  = 1'b1;
      end
      S_MUL_LO: begin
        mul_a    = US_LO;
        mul_b    = num;
        acc_base = BASE_ACC;
        acc_load = 1'b1;
      end
      S_BLEND_NEW: begin
        mul_a    = phase ? acc_gain_new : vel_gain_new;
        mul_b    = DIFF_W'(raw);
        acc_base = BASE_ROUND;
        acc_load = 1'b1;
      end
      S_BLEND_OLD: begin
        mul_a    = phase ? acc_gain_old : vel_gain_old;
        mul_b    = phase ? DIFF_W'(accel[axis]) : DIFF_W'(vel[axis]);
        acc_base = BASE_ACC;
        acc_load = 1'b1;
      end
      default: begin
        acc_load = 1'b0;
      end
    endcase
  end

  // shared multiply-accumulate
  assign prod     = $signed({1'b0, mul_a}) * mul_b;
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign addend   = mul_shift ? (prod_ext <<< 16) : prod_ext;

  always_comb begin
    case (acc_base)
      BASE_ACC:   base_val = acc;
      BASE_ROUND: base_val = $signed(ROUND_HALF);
      default:    base_val = '0;
    endcase
  end

  assign acc_sum = base_val + addend;

  // divider: magnitude plus half the interval, then restoring steps
  assign half_den = den >> 1;
  assign dividend = acc[ACC_W-1] ? ({{(ACC_W - DATA_W){1'b0}}, half_den} - acc)
                                 : (acc + {{(ACC_W - DATA_W){1'b0}}, half_den});
  assign div_hi   = acc[DATA_W+DIVD_HI_W-1:DATA_W];
  assign r2       = {rem, quo[DATA_W-1]};
  assign r2_sub   = r2 - {1'b0, den};
  assign ge       = (r2 >= {1'b0, den});

  always_comb begin
    if (neg) begin
      if (sat || (quo[DATA_W-1] && (quo[DATA_W-2:0] != '0))) begin
        div_res = Q_MIN;
      end else begin
        div_res = $signed(-quo);
      end
    end else begin
      if (sat || quo[DATA_W-1]) begin
        div_res = Q_MAX;
      end else begin
        div_res = $signed(quo);
      end
    end
  end

  // filter output: floor shift by 15 and saturate
  assign blend_sh = acc[ACC_W-1:15];

  always_comb begin
    if (blend_sh > BLEND_W'(Q_MAX)) begin
      blend_res = Q_MAX;
    end else if (blend_sh < BLEND_W'(Q_MIN)) begin
      blend_res = Q_MIN;
    end else begin
      blend_res = blend_sh[DATA_W-1:0];
    end
  end

  // estimate fields, unused axes read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vel_out[i] = '0;
      acc_out[i] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      vel_out[i] = vel[i];
      acc_out[i] = accel[i];
    end
    est_next.vel_x   = vel_out[0];
    est_next.vel_y   = vel_out[1];
    est_next.vel_z   = vel_out[2];
    est_next.acc_x   = acc_out[0];
    est_next.acc_y   = acc_out[1];
    est_next.acc_z   = acc_out[2];
    est_next.updated = advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // gains, filter state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_gain_new <= GAIN_ONE;
      vel_gain_old <= GAIN_ZERO;
      acc_gain_new <= GAIN_ONE;
      acc_gain_old <= GAIN_ZERO;
      prev_stamp   <= '0;
      have_prev    <= 1'b0;
      est_valid    <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        prev_pos[i] <= '0;
        vel[i]      <= '0;
        accel[i]    <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_VEL_GAIN_NEW: vel_gain_new <= cfg_data;
          REG_VEL_GAIN_OLD: vel_gain_old <= cfg_data;
          REG_ACC_GAIN_NEW: acc_gain_new <= cfg_data;
          REG_ACC_GAIN_OLD: acc_gain_old <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_FINISH && est_free) begin
        est_valid <= 1'b1;
      end else if (est_valid && !est_stall) begin
        est_valid <= 1'b0;
      end

      if (state == S_BLEND_DONE) begin
        if (phase) begin
          accel[axis] <= blend_res;
        end else begin
          vel[axis] <= blend_res;
        end
      end

      // repeating this while the output is held is harmless
      if (state == S_FINISH) begin
        prev_stamp <= cur.stamp_us;
        have_prev  <= 1'b1;
        for (int i = 0; i < AXES; i++) begin
          prev_pos[i] <= cur_pos[i];
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == S_FINISH && est_free) begin
      est <= est_next;
    end

    if (acc_load) begin
      acc <= acc_sum;
    end

    case (state)
      S_IDLE: begin
        if (meas_valid) begin
          cur     <= meas;
          den     <= interval;
          advance <= adv_now;
          axis    <= '0;
          phase   <= 1'b0;
        end
      end
      S_DIFF: begin
        if (phase) begin
          num <= DIFF_W'(vel[axis]) - DIFF_W'(vold);
        end else begin
          num <= DIFF_W'(cur_pos[axis]) - DIFF_W'(prev_pos[axis]);
        end
      end
      S_DIV_PREP: begin
        neg <= acc[ACC_W-1];
        acc <= $signed(dividend);
      end
      S_DIV_LOAD: begin
        sat     <= ({{(DATA_W - DIVD_HI_W){1'b0}}, div_hi} >= den);
        rem     <= {{(DATA_W - DIVD_HI_W){1'b0}}, div_hi};
        quo     <= acc[DATA_W-1:0];
        bit_cnt <= '0;
      end
      S_DIV_ITER: begin
        rem     <= ge ? r2_sub[DATA_W-1:0] : r2[DATA_W-1:0];
        quo     <= {quo[DATA_W-2:0], ge};
        bit_cnt <= bit_cnt + 1'b1;
      end
      S_DIV_DONE: begin
        raw <= div_res;
      end
      S_BLEND_DONE: begin
        if (phase) begin
          phase <= 1'b0;
          axis  <= axis + 1'b1;
        end else begin
          vold  <= vel[axis];
          phase <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/sv/vae_estimate_checker.sv
// checker: predicts each velocity and acceleration estimate and compares it with the block
module vae_estimate_checker
  import vae_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 meas_valid,
  input  logic                 meas_stall,
  input  meas_t                meas,
  input  logic                 est_valid,
  input  logic                 est_stall,
  input  est_t                 est,
  output int                   mismatch_count,
  output int                   pending
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int     EXP_DEPTH = 16;

  logic [GAIN_W-1:0]  vel_gain_new;
  logic [GAIN_W-1:0]  vel_gain_old;
  logic [GAIN_W-1:0]  acc_gain_new;
  logic [GAIN_W-1:0]  acc_gain_old;
  logic [STAMP_W-1:0] last_stamp;
  logic               seen_sample;
  longint             last_pos [AXES];
  longint             vel_filt [AXES];
  longint             acc_filt [AXES];
  est_t               expected_estimates [EXP_DEPTH];
  logic [3:0]         exp_head;
  logic [3:0]         exp_tail;
  int                 exp_count;
  est_t               want_est;
  int                 estimate_no;
  int                 k;

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 200) begin
      $display("estimate %0d: %s", estimate_no, msg);
    end
    mismatch_count++;
  endtask

  function automatic longint clamp32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // delta * 1e6 / interval, nearest with ties away from zero
  function automatic longint per_second(longint delta, logic [STAMP_W-1:0] span_us);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    den = span_us;
    mag = (delta < 0) ? -delta : delta;
    q = (mag * 64'd1000000 + (den >> 1)) / den;
    if (delta < 0) begin
      return (q > 64'd2147483648) ? SAT_LO : -longint'(q);
    end
    return clamp32(longint'(q));
  endfunction

  // first-order filter step; arithmetic shift gives floor after the half-up offset
  function automatic longint mix(logic [GAIN_W-1:0] g_fresh, longint fresh,
                                 logic [GAIN_W-1:0] g_prev, longint prev);
    longint gf;
    longint gp;
    longint s;
    gf = g_fresh;
    gp = g_prev;
    s = gf * fresh + gp * prev + 64'sd16384;
    return clamp32(s >>> 15);
  endfunction

  function automatic est_t predict_estimate(meas_t m);
    logic signed [DATA_W-1:0] pos_in [3];
    logic [STAMP_W-1:0]       span_us;
    logic                     advance;
    longint                   pos;
    longint                   v_prev;
    longint                   v_new;
    longint                   v_out [3];
    longint                   a_out [3];
    est_t                     e;
    int                       i;
    pos_in[0] = m.pos_x;
    pos_in[1] = m.pos_y;
    pos_in[2] = m.pos_z;
    span_us = m.stamp_us - last_stamp;
    advance = seen_sample && (span_us != '0);
    for (i = 0; i < AXES; i++) begin
      pos = pos_in[i];
      if (advance) begin
        v_prev = vel_filt[i];
        v_new = mix(vel_gain_new, per_second(pos - last_pos[i], span_us),
                    vel_gain_old, v_prev);
        vel_filt[i] = v_new;
        acc_filt[i] = mix(acc_gain_new, per_second(v_new - v_prev, span_us),
                          acc_gain_old, acc_filt[i]);
      end
      last_pos[i] = pos;
    end
    last_stamp = m.stamp_us;
    seen_sample = 1'b1;
    // axes beyond AXES read as zero
    for (i = 0; i < 3; i++) begin
      v_out[i] = 0;
      a_out[i] = 0;
    end
    for (i = 0; i < AXES; i++) begin
      v_out[i] = vel_filt[i];
      a_out[i] = acc_filt[i];
    end
    e.vel_x = v_out[0][DATA_W-1:0];
    e.vel_y = v_out[1][DATA_W-1:0];
    e.vel_z = v_out[2][DATA_W-1:0];
    e.acc_x = a_out[0][DATA_W-1:0];
    e.acc_y = a_out[1][DATA_W-1:0];
    e.acc_z = a_out[2][DATA_W-1:0];
    e.updated = advance;
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vel_gain_new = GAIN_ONE;
      vel_gain_old = GAIN_ZERO;
      acc_gain_new = GAIN_ONE;
      acc_gain_old = GAIN_ZERO;
      last_stamp = '0;
      seen_sample = 1'b0;
      for (k = 0; k < AXES; k++) begin
        last_pos[k] = 0;
        vel_filt[k] = 0;
        acc_filt[k] = 0;
      end
      exp_head = '0;
      exp_tail = '0;
      exp_count = 0;
      estimate_no = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_VEL_GAIN_NEW: vel_gain_new = cfg_data;
          REG_VEL_GAIN_OLD: vel_gain_old = cfg_data;
          REG_ACC_GAIN_NEW: acc_gain_new = cfg_data;
          REG_ACC_GAIN_OLD: acc_gain_old = cfg_data;
          default: ;
        endcase
      end
      if (est_valid && !est_stall) begin
        if (exp_count == 0) begin
          flag_mismatch("estimate with no request waiting");
        end else begin
          want_est = expected_estimates[exp_head];
          exp_head = exp_head + 4'd1;
          exp_count--;
          if (est.vel_x !== want_est.vel_x)
            flag_mismatch($sformatf("vel_x %0d, expected %0d", est.vel_x, want_est.vel_x));
          if (est.vel_y !== want_est.vel_y)
            flag_mismatch($sformatf("vel_y %0d, expected %0d", est.vel_y, want_est.vel_y));
          if (est.vel_z !== want_est.vel_z)
            flag_mismatch($sformatf("vel_z %0d, expected %0d", est.vel_z, want_est.vel_z));
          if (est.acc_x !== want_est.acc_x)
            flag_mismatch($sformatf("acc_x %0d, expected %0d", est.acc_x, want_est.acc_x));
          if (est.acc_y !== want_est.acc_y)
            flag_mismatch($sformatf("acc_y %0d, expected %0d", est.acc_y, want_est.acc_y));
          if (est.acc_z !== want_est.acc_z)
            flag_mismatch($sformatf("acc_z %0d, expected %0d", est.acc_z, want_est.acc_z));
          if (est.updated !== want_est.updated)
            flag_mismatch($sformatf("updated %b, expected %b", est.updated,
                                    want_est.updated));
        end
        estimate_no++;
      end
      if (meas_valid && !meas_stall) begin
        if (exp_count == EXP_DEPTH) begin
          flag_mismatch("too many requests outstanding");
        end else begin
          expected_estimates[exp_tail] = predict_estimate(meas);
          exp_tail = exp_tail + 4'd1;
          exp_count++;
        end
      end
    end
    pending = exp_count;
  end

endmodule

// File: tb/sv/velocity_acceleration_estimator_tb.sv
// testbench top: position sample stimulus, gain settings and verdict for the estimator
module velocity_acceleration_estimator_tb;
  import vae_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_VEL_GAIN_NEW;
  logic [GAIN_W-1:0]        cfg_data = GAIN_ZERO;
  logic                     meas_valid = 1'b0;
  logic                     meas_stall;
  meas_t                    meas = '0;
  logic                     est_valid;
  logic                     est_stall = 1'b0;
  est_t                     est;
  int                       mismatch_count;
  int                       pending_estimates;

  logic [STAMP_W-1:0]       track_stamp = '0;
  logic signed [DATA_W-1:0] track_pos [3] = '{default: '0};
  int unsigned              burst_left = 0;
  int unsigned              stall_left = 0;
  logic                     stall_level = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  velocity_acceleration_estimator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .meas       (meas),
    .est_valid  (est_valid),
    .est_stall  (est_stall),
    .est        (est)
  );

  vae_estimate_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .meas_valid     (meas_valid),
    .meas_stall     (meas_stall),
    .meas           (meas),
    .est_valid      (est_valid),
    .est_stall      (est_stall),
    .est            (est),
    .mismatch_count (mismatch_count),
    .pending        (pending_estimates)
  );

  // output side: runs of stall and of free flow, mostly short, now and then long
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_level = ~stall_level;
      if (stall_level) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 500)
                                                  : $urandom_range(1, 6);
      end else begin
        stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 1500)
                                                  : $urandom_range(1, 40);
      end
    end
    stall_left--;
    est_stall <= stall_level;
  end

  // requests go out in bursts with random gaps between them
  task automatic issue(meas_t m);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        meas_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    meas <= m;
    meas_valid <= 1'b1;
    @(posedge clk);
    while (meas_stall) @(posedge clk);
    track_stamp = m.stamp_us;
    track_pos[0] = m.pos_x;
    track_pos[1] = m.pos_y;
    track_pos[2] = m.pos_z;
    @(negedge clk);
  endtask

  task automatic drain();
    meas_valid <= 1'b0;
    while (pending_estimates != 0) @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [GAIN_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_write <= 1'b1;
    @(negedge clk);
  endtask

  task automatic load_gains(logic [GAIN_W-1:0] vn, logic [GAIN_W-1:0] vo,
                            logic [GAIN_W-1:0] an, logic [GAIN_W-1:0] ao);
    put_reg(REG_VEL_GAIN_NEW, vn);
    put_reg(REG_VEL_GAIN_OLD, vo);
    put_reg(REG_ACC_GAIN_NEW, an);
    put_reg(REG_ACC_GAIN_OLD, ao);
    cfg_write <= 1'b0;
  endtask

  // mostly a plausible trajectory, with noise, wraps and position jumps mixed in
  function automatic meas_t next_sample();
    meas_t                    m;
    int unsigned              kind;
    int unsigned              span;
    logic signed [DATA_W-1:0] step [3];
    int                       i;
    kind = $urandom_range(0, 99);
    span = 1 << $urandom_range(2, 20);
    for (i = 0; i < 3; i++) begin
      step[i] = $urandom_range(0, span) - span / 2;
    end
    m.stamp_us = track_stamp;
    m.pos_x = track_pos[0] + step[0];
    m.pos_y = track_pos[1] + step[1];
    m.pos_z = track_pos[2] + step[2];
    if (kind < 60) begin
      m.stamp_us = track_stamp + $urandom_range(1000, 20000);
    end else if (kind < 70) begin
      m.stamp_us = track_stamp + $urandom_range(1, 64);
    end else if (kind < 78) begin
      m = {$urandom, $urandom, $urandom, $urandom};
    end else if (kind < 84) begin
      m.stamp_us = track_stamp + $urandom;
    end else if (kind < 88) begin
      m.stamp_us = 32'hffff_ffff - $urandom_range(0, 20000);
    end else if (kind < 92) begin
      m.stamp_us = track_stamp + $urandom_range(1, 8);
      m.pos_x = $urandom;
      m.pos_y = $urandom;
      m.pos_z = $urandom;
    end
    // otherwise the stamp repeats: zero interval
    return m;
  endfunction

  initial begin
    logic [GAIN_W-1:0] g_vel;
    logic [GAIN_W-1:0] g_acc;
    int                phase;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset gains: first sample, zero interval, saturating swings, rounding, wraps
    issue(meas_t'{32'd0, Q_MAX, Q_MIN, 32'sd0});
    issue(meas_t'{32'd0, Q_MIN, Q_MAX, 32'sd5});
    issue(meas_t'{32'd1, Q_MAX, Q_MIN, -32'sd5});
    issue(meas_t'{32'd2, Q_MIN, Q_MAX, 32'sd5});
    issue(meas_t'{32'd1002, Q_MIN, Q_MAX, 32'sd5});
    // one unit over two seconds: half-way rates round away from zero
    issue(meas_t'{32'd2001002, Q_MIN + 32'sd1, Q_MAX - 32'sd1, 32'sd5});
    issue(meas_t'{32'd2001005, Q_MIN + 32'sd2, Q_MAX - 32'sd2, 32'sd6});
    issue(meas_t'{32'hffff_ff00, 32'sd0, 32'sd0, 32'sd0});
    issue(meas_t'{32'h0000_0100, 32'sd65536, -32'sd65536, 32'sd1});
    // stamp one below the previous: interval of all ones
    issue(meas_t'{32'h0000_00ff, Q_MAX, Q_MIN, Q_MAX});
    issue(meas_t'{32'h0000_00ff, 32'sd0, 32'sd0, 32'sd0});
    repeat (10) begin
      issue(meas_t'{track_stamp + 32'd10000, track_pos[0] + 32'sd6554,
                    track_pos[1] - 32'sd13107, track_pos[2] + 32'sd65});
    end
    drain();

    for (phase = 1; phase <= 12; phase++) begin
      case (phase)
        1: load_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
        2: load_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        3: load_gains(16'd16384, 16'd16384, 16'd16384, 16'd16384);
        4: load_gains(GAIN_ONE, GAIN_ZERO, GAIN_ONE, GAIN_ZERO);
        5: load_gains(16'd8192, 16'd24576, 16'd4096, 16'd28672);
        default: begin
          g_vel = GAIN_W'($urandom_range(0, 32768));
          g_acc = GAIN_W'($urandom_range(0, 32768));
          if (phase % 3 == 0) begin
            load_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                       GAIN_W'($urandom));
          end else begin
            load_gains(g_vel, GAIN_ONE - g_vel, g_acc, GAIN_ONE - g_acc);
          end
        end
      endcase
      repeat (120) issue(next_sample());
      drain();
    end

    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && pending_estimates == 0) begin
      $display("PASS velocity_acceleration_estimator");
    end else begin
      $display("FAIL velocity_acceleration_estimator");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL velocity_acceleration_estimator");
    $finish;
  end

endmodule

// File: files.f
rtl/vae_pkg.sv
rtl/velocity_acceleration_estimator.sv
tb/sv/vae_estimate_checker.sv
tb/sv/velocity_acceleration_estimator_tb.sv
